// ----- rtl/core/bdls_pkg.sv -----
`default_nettype none
package bdls_pkg;

  localparam int unsigned MAX_DABS_DEFAULT = 64;

  localparam logic [19:0] BRUSH_SIZE_RESET = 20'd2560;
  localparam logic [11:0] SPACING_RESET    = 12'd256;

  // Radicand and dividend width, root/quotient/remainder width.
  localparam int OPERAND_W  = 50;
  localparam int RESULT_W   = 25;
  localparam int ROOT_STEPS = 25;
  localparam int DIV_STEPS  = 24;
  localparam int STEP_CNT_W = 5;

  typedef enum logic {
    REG_BRUSH_SIZE = 1'b0,
    REG_SPACING    = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    OP_MOVE = 1'b0,
    OP_LINE = 1'b1
  } op_code_t;

  typedef enum logic {
    MODE_ROOT = 1'b0,
    MODE_DIV  = 1'b1
  } unit_mode_t;

  typedef struct packed {
    logic       start;
    unit_mode_t mode;
  } unit_req_t;

endpackage
`default_nettype wire

// ----- rtl/core/bdls_rootdiv.sv -----
`default_nettype none
// Shared compare-and-subtract unit. In root mode it retires two radicand bits
// per cycle of a 50-bit radicand; in divide mode one quotient bit per cycle,
// with the quotient known to fit in 24 bits.
module bdls_rootdiv (
  input  logic                                   clk,
  input  logic                                   rst,
  input  bdls_pkg::unit_req_t                    req,
  input  logic [bdls_pkg::OPERAND_W-1:0]         operand,
  input  logic [bdls_pkg::RESULT_W-1:0]          divisor,
  output logic                                   done,
  output logic [bdls_pkg::RESULT_W-1:0]          quot,
  output logic [bdls_pkg::RESULT_W-1:0]          rem_out
);

  bdls_pkg::unit_mode_t                 mode_r;
  logic                                 busy;
  logic [bdls_pkg::STEP_CNT_W-1:0]      cnt;
  logic [bdls_pkg::OPERAND_W-1:0]       sh;
  logic [bdls_pkg::RESULT_W-1:0]        rem;
  logic [bdls_pkg::RESULT_W-1:0]        res;
  logic [bdls_pkg::RESULT_W-1:0]        divisor_r;
  logic [bdls_pkg::RESULT_W+1:0]        cand;
  logic [bdls_pkg::RESULT_W+1:0]        trial;
  logic [bdls_pkg::RESULT_W+2:0]        diff;
  logic                                 ge;

  always_comb begin
    if (mode_r == bdls_pkg::MODE_ROOT) begin
      cand  = {rem, sh[bdls_pkg::OPERAND_W-1 -: 2]};
      trial = {res, 2'b01};
    end else begin
      cand  = {1'b0, rem, sh[bdls_pkg::OPERAND_W-1]};
      trial = {2'b00, divisor_r};
    end
    diff = {1'b0, cand} - {1'b0, trial};
    ge   = ~diff[bdls_pkg::RESULT_W+2];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && !req.start && (cnt == bdls_pkg::STEP_CNT_W'(1));
      if (req.start) begin
        mode_r    <= req.mode;
        busy      <= 1'b1;
        res       <= '0;
        divisor_r <= divisor;
        if (req.mode == bdls_pkg::MODE_ROOT) begin
          cnt <= bdls_pkg::STEP_CNT_W'(bdls_pkg::ROOT_STEPS);
          sh  <= operand;
          rem <= '0;
        end else begin
          // The upper half is already below the divisor since the quotient fits.
          cnt <= bdls_pkg::STEP_CNT_W'(bdls_pkg::DIV_STEPS);
          sh  <= {operand[23:0], 26'd0};
          rem <= {1'b0, operand[47:24]};
        end
      end else if (busy) begin
        res <= {res[bdls_pkg::RESULT_W-2:0], ge};
        rem <= ge ? diff[bdls_pkg::RESULT_W-1:0] : cand[bdls_pkg::RESULT_W-1:0];
        if (mode_r == bdls_pkg::MODE_ROOT) begin
          sh <= {sh[bdls_pkg::OPERAND_W-3:0], 2'b00};
        end else begin
          sh <= {sh[bdls_pkg::OPERAND_W-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == bdls_pkg::STEP_CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign quot    = res;
  assign rem_out = rem;

endmodule
`default_nettype wire

// ----- rtl/core/brush_dab_line_stepper_core.sv -----
`default_nettype none
// Channel   Direction  Handshake              Payload
// in        in         in_valid / in_ready    op, point_x, point_y
// out       out        out_valid / out_ready  dab_left, dab_top, last_dab
// cfg       in         cfg_we                 cfg_index, cfg_data
//
// A move transaction updates the pen on acceptance. A line transaction first runs its
// setup (one square root and two divisions on the shared root/divide unit, at one or
// two bits a cycle), then emits its dabs one by one and finally updates the pen; a
// line that places no dab returns to idle after the length check. The input is
// not ready while a transaction is in work, and output stalls hold dab emission in
// place. Synchronous reset clears the pen to the origin and the registers to defaults.
module brush_dab_line_stepper_core #(
  parameter int unsigned MAX_DABS = bdls_pkg::MAX_DABS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               op,
  input  logic signed [23:0] point_x,
  input  logic signed [23:0] point_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [23:0] dab_left,
  output logic signed [23:0] dab_top,
  output logic               last_dab,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_index,
  input  logic [19:0]        cfg_data
);

  localparam int NW = $clog2(MAX_DABS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_SQ_X, S_SQ_Y, S_SQ_SUM, S_ROOT_GO, S_ROOT_WAIT, S_CHECK,
    S_MUL_X, S_DIV_X_GO, S_DIV_X_WAIT, S_MUL_Y, S_DIV_Y_GO, S_DIV_Y_WAIT,
    S_EMIT, S_PEN
  } state_t;

  state_t state;

  logic [19:0]        brush_size;
  logic [11:0]        spacing;
  logic signed [23:0] pen_x;
  logic signed [23:0] pen_y;
  logic               sx;
  logic               sy;
  logic [23:0]        mag_x;
  logic [23:0]        mag_y;
  logic [47:0]        prod;
  logic [48:0]        sumsq;
  logic [21:0]        step;
  logic [24:0]        len;
  logic [23:0]        qsx;
  logic [23:0]        qsy;
  logic [24:0]        rsx;
  logic [24:0]        rsy;
  logic [23:0]        offx;
  logic [23:0]        offy;
  logic [24:0]        remx;
  logic [24:0]        remy;
  logic [NW-1:0]      n;
  logic [26:0]        nxt;

  logic [23:0]        mul_a;
  logic [23:0]        mul_b;
  logic signed [24:0] dxw;
  logic signed [24:0] dyw;
  logic signed [25:0] cx;
  logic signed [25:0] cy;
  logic signed [26:0] lx;
  logic signed [26:0] ly;
  logic [25:0]        rsum_x;
  logic [25:0]        rsum_y;
  logic               wrap_x;
  logic               wrap_y;
  logic               last;
  logic               out_free;

  bdls_pkg::unit_req_t              req;
  logic [bdls_pkg::OPERAND_W-1:0]   operand;
  logic                             unit_done;
  logic [bdls_pkg::RESULT_W-1:0]    unit_quot;
  logic [bdls_pkg::RESULT_W-1:0]    unit_rem;

  function automatic logic [23:0] sat24(input logic signed [26:0] v);
    logic [23:0] r;
    if (v > 27'sd8388607) begin
      r = 24'h7FFFFF;
    end else if (v < -27'sd8388608) begin
      r = 24'h800000;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

  bdls_rootdiv u_rootdiv (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .operand (operand),
    .divisor (len),
    .done    (unit_done),
    .quot    (unit_quot),
    .rem_out (unit_rem)
  );

  assign in_ready = (state == S_IDLE) && !rst;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    req.start = (state == S_ROOT_GO) || (state == S_DIV_X_GO) || (state == S_DIV_Y_GO);
    req.mode  = (state == S_ROOT_GO) ? bdls_pkg::MODE_ROOT : bdls_pkg::MODE_DIV;
    operand   = (state == S_ROOT_GO) ? {1'b0, sumsq} : {2'b00, prod};
  end

  // One shared multiplier; its product is always registered.
  always_comb begin
    case (state)
      S_SQ_X:   begin mul_a = mag_x;              mul_b = mag_x;             end
      S_SQ_Y:   begin mul_a = mag_y;              mul_b = mag_y;             end
      S_SQ_SUM: begin mul_a = {4'd0, brush_size}; mul_b = {12'd0, spacing}; end
      S_MUL_X:  begin mul_a = mag_x;              mul_b = {2'd0, step};      end
      S_MUL_Y:  begin mul_a = mag_y;              mul_b = {2'd0, step};      end
      default:  begin mul_a = '0;                 mul_b = '0;                end
    endcase
  end

  always_comb begin
    dxw = {point_x[23], point_x} - {pen_x[23], pen_x};
    dyw = {point_y[23], point_y} - {pen_y[23], pen_y};

    cx = {{2{pen_x[23]}}, pen_x} + (sx ? -{2'b00, offx} : {2'b00, offx});
    cy = {{2{pen_y[23]}}, pen_y} + (sy ? -{2'b00, offy} : {2'b00, offy});
    lx = {cx[25], cx} - {8'd0, brush_size[19:1]};
    ly = {cy[25], cy} - {8'd0, brush_size[19:1]};

    // Running remainder of the rounded offset; a wrap carries one into the offset.
    rsum_x = {1'b0, remx} + {1'b0, rsx};
    rsum_y = {1'b0, remy} + {1'b0, rsy};
    wrap_x = rsum_x >= {1'b0, len};
    wrap_y = rsum_y >= {1'b0, len};

    last = (n == NW'(MAX_DABS - 1)) || (nxt > {2'b00, len});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      pen_x      <= '0;
      pen_y      <= '0;
      out_valid  <= 1'b0;
      brush_size <= bdls_pkg::BRUSH_SIZE_RESET;
      spacing    <= bdls_pkg::SPACING_RESET;
    end else begin
      if (cfg_we) begin
        case (bdls_pkg::cfg_reg_t'(cfg_index))
          bdls_pkg::REG_BRUSH_SIZE: brush_size <= cfg_data;
          bdls_pkg::REG_SPACING:    spacing    <= cfg_data[11:0];
          default: ;
        endcase
      end

      if (state == S_EMIT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      prod <= mul_a * mul_b;

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (bdls_pkg::op_code_t'(op) == bdls_pkg::OP_LINE) begin
              sx    <= dxw[24];
              sy    <= dyw[24];
              mag_x <= dxw[24] ? 24'(-dxw) : dxw[23:0];
              mag_y <= dyw[24] ? 24'(-dyw) : dyw[23:0];
              state <= S_SQ_X;
            end else begin
              pen_x <= point_x;
              pen_y <= point_y;
            end
          end
        end
        S_SQ_X:   state <= S_SQ_Y;
        S_SQ_Y: begin
          sumsq <= {1'b0, prod};
          state <= S_SQ_SUM;
        end
        S_SQ_SUM: begin
          sumsq <= sumsq + {1'b0, prod};
          state <= S_ROOT_GO;
        end
        S_ROOT_GO: begin
          // A step below one LSB is raised to one LSB.
          step  <= (prod[31:10] == '0) ? 22'd1 : prod[31:10];
          state <= S_ROOT_WAIT;
        end
        S_ROOT_WAIT: begin
          if (unit_done) begin
            len   <= unit_quot;
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          // A segment shorter than one step, zero length included, places no dab.
          state <= (len < {3'd0, step}) ? S_IDLE : S_MUL_X;
        end
        S_MUL_X:    state <= S_DIV_X_GO;
        S_DIV_X_GO: state <= S_DIV_X_WAIT;
        S_DIV_X_WAIT: begin
          if (unit_done) begin
            qsx   <= unit_quot[23:0];
            rsx   <= unit_rem;
            state <= S_MUL_Y;
          end
        end
        S_MUL_Y:    state <= S_DIV_Y_GO;
        S_DIV_Y_GO: state <= S_DIV_Y_WAIT;
        S_DIV_Y_WAIT: begin
          if (unit_done) begin
            qsy   <= unit_quot[23:0];
            rsy   <= unit_rem;
            offx  <= '0;
            offy  <= '0;
            remx  <= {1'b0, len[24:1]};
            remy  <= {1'b0, len[24:1]};
            n     <= '0;
            nxt   <= {4'd0, step, 1'b0};
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            dab_left  <= sat24(lx);
            dab_top   <= sat24(ly);
            last_dab  <= last;
            offx      <= offx + qsx + {23'd0, wrap_x};
            offy      <= offy + qsy + {23'd0, wrap_y};
            remx      <= wrap_x ? 25'(rsum_x - {1'b0, len}) : rsum_x[24:0];
            remy      <= wrap_y ? 25'(rsum_y - {1'b0, len}) : rsum_y[24:0];
            nxt       <= nxt + {5'd0, step};
            n         <= n + 1'b1;
            if (last) begin
              state <= S_PEN;
            end
          end
        end
        S_PEN: begin
          // The offsets now stand one step past the last dab.
          pen_x <= cx[23:0];
          pen_y <= cy[23:0];
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_done_when_waiting: assert property (@(posedge clk) disable iff (rst)
    unit_done |-> (state == S_ROOT_WAIT || state == S_DIV_X_WAIT ||
                   state == S_DIV_Y_WAIT))
    else $error("root/divide unit finished while no result was awaited");

  a_rem_below_len: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> (remx < len && remy < len))
    else $error("offset remainder reached the segment length");

  a_dab_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> (n <= NW'(MAX_DABS - 1)))
    else $error("dab count went past the cap");

  a_pen_after_last: assert property (@(posedge clk) disable iff (rst)
    (state == S_PEN) |-> (out_valid && last_dab))
    else $error("pen update without a final dab in the output register");

endmodule
`default_nettype wire

// ----- tb/brush_dab_line_stepper_core_test.sv -----
`timescale 1ns / 100ps

module brush_dab_line_stepper_core_test;

  localparam int DAB_CAP = 64;
  localparam int EDGE_LO = -8388608;
  localparam int EDGE_HI = 8388607;
  localparam int SETTLE_CYCLES = 150;
  localparam int DRAIN_CYCLES = 200;

  typedef struct packed {
    logic signed [23:0] left;
    logic signed [23:0] top;
    logic               last;
  } dab_t;

  // For setup rows, x carries the brush size and y the spacing.
  typedef struct {
    bit                 setup;
    bdls_pkg::op_code_t op;
    int                 x;
    int                 y;
    int                 pins;
    int                 l0;
    int                 t0;
    int                 l1;
    int                 t1;
  } plan_row_t;

  logic               clk;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               op = 1'b0;
  logic signed [23:0] point_x = '0;
  logic signed [23:0] point_y = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [23:0] dab_left;
  logic signed [23:0] dab_top;
  logic               last_dab;
  logic               cfg_we = 1'b0;
  logic [0:0]         cfg_index = '0;
  logic [19:0]        cfg_data = '0;

  // Shadow copy of the block's registers and pen.
  logic [19:0]        brush_reg = bdls_pkg::BRUSH_SIZE_RESET;
  logic [11:0]        space_reg = bdls_pkg::SPACING_RESET;
  logic signed [23:0] pen_x = '0;
  logic signed [23:0] pen_y = '0;

  dab_t      dabs_due[$];
  dab_t      fresh[$];
  plan_row_t plan[$];
  dab_t      want;
  int        faults = 0;
  int        out_hold = 0;
  bit        smooth = 1'b0;

  brush_dab_line_stepper_core #(.MAX_DABS(DAB_CAP)) dut (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int unsigned idle_span();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic signed [23:0] clamp24(input longint v);
    if (v < EDGE_LO) return 24'(EDGE_LO);
    if (v > EDGE_HI) return 24'(EDGE_HI);
    return v[23:0];
  endfunction

  // Largest r with r*r <= v, found bit by bit from the top.
  function automatic longint floor_root(input longint v);
    longint r, probe;
    r = 0;
    for (int b = 25; b >= 0; b--) begin
      probe = r | (longint'(1) << b);
      if (probe * probe <= v) r = probe;
    end
    return r;
  endfunction

  // Signed share d * part / whole, magnitude rounded half up.
  function automatic longint share_of(input longint d, input longint part, input longint whole);
    longint mag, q;
    mag = (d < 0) ? -d : d;
    q = (mag * part + (whole >> 1)) / whole;
    return (d < 0) ? -q : q;
  endfunction

  function automatic longint dab_stride();
    longint s;
    s = (longint'(brush_reg) * longint'(space_reg)) >> 10;
    return (s == 0) ? 1 : s;
  endfunction

  // Works out the dabs of one transaction into fresh[] and moves the pen.
  function automatic void trace_segment(input bdls_pkg::op_code_t o,
                                        input logic signed [23:0] px,
                                        input logic signed [23:0] py);
    longint dx, dy, seg_len, stride, count, half, cx, cy;
    dab_t   d;
    fresh.delete();
    if (o == bdls_pkg::OP_MOVE) begin
      pen_x = px;
      pen_y = py;
      return;
    end
    dx = longint'(px) - longint'(pen_x);
    dy = longint'(py) - longint'(pen_y);
    seg_len = floor_root(dx * dx + dy * dy);
    if (seg_len == 0) return;
    stride = dab_stride();
    count = seg_len / stride;
    if (count > DAB_CAP) count = DAB_CAP;
    if (count == 0) return;
    half = longint'(brush_reg >> 1);
    for (longint n = 0; n < count; n++) begin
      cx = longint'(pen_x) + share_of(dx, n * stride, seg_len);
      cy = longint'(pen_y) + share_of(dy, n * stride, seg_len);
      d.left = clamp24(cx - half);
      d.top = clamp24(cy - half);
      d.last = (n + 1 == count);
      fresh.push_back(d);
    end
    pen_x = clamp24(longint'(pen_x) + share_of(dx, count * stride, seg_len));
    pen_y = clamp24(longint'(pen_y) + share_of(dy, count * stride, seg_len));
  endfunction

  function automatic void add_row(input bit setup, input bdls_pkg::op_code_t o, input int x,
                                  input int y, input int pins, input int l0 = 0,
                                  input int t0 = 0, input int l1 = 0, input int t1 = 0);
    plan_row_t r;
    r.setup = setup;
    r.op = o;
    r.x = x;
    r.y = y;
    r.pins = pins;
    r.l0 = l0;
    r.t0 = t0;
    r.l1 = l1;
    r.t1 = t1;
    plan.push_back(r);
  endfunction

  task automatic offer_point(input bdls_pkg::op_code_t o, input int x, input int y);
    in_valid <= 1'b1;
    op <= o;
    point_x <= 24'(x);
    point_y <= 24'(y);
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    trace_segment(o, 24'(x), 24'(y));
  endtask

  task automatic rest_input();
    int unsigned g;
    g = smooth ? 0 : idle_span();
    if (g != 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // Waits until the block has gone quiet, then reprograms both registers.
  task automatic program_brush(input int bs, input int sp);
    in_valid <= 1'b0;
    while (dabs_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= bdls_pkg::REG_BRUSH_SIZE;
    cfg_data <= 20'(bs);
    @(posedge clk);
    cfg_index <= bdls_pkg::REG_SPACING;
    cfg_data <= 20'(sp);
    @(posedge clk);
    cfg_we <= 1'b0;
    brush_reg = 20'(bs);
    space_reg = 12'(sp);
  endtask

  // Mostly lines that land a few steps from the pen, with some jumps and noise.
  task automatic random_item();
    int unsigned        pick;
    longint             stride, reach, off, tx, ty;
    logic signed [23:0] raw_x, raw_y;
    bdls_pkg::op_code_t o;
    stride = dab_stride();
    pick = $urandom_range(0, 99);
    o = bdls_pkg::OP_LINE;
    tx = pen_x;
    ty = pen_y;
    raw_x = 24'($urandom);
    raw_y = 24'($urandom);
    if (pick < 8) begin
      o = bdls_pkg::OP_MOVE;
      tx = raw_x;
      ty = raw_y;
    end else if (pick < 12) begin
      o = bdls_pkg::OP_MOVE;
      tx = $urandom_range(0, 1) ? EDGE_HI : EDGE_LO;
      ty = $urandom_range(0, 1) ? EDGE_HI : EDGE_LO;
    end else if (pick < 18) begin
      tx = raw_x;
      ty = raw_y;
    end else if (pick < 22) begin
      // Line back onto the pen itself.
    end else if (pick < 30) begin
      off = stride * $urandom_range(0, 66);
      if ($urandom_range(0, 1)) off = -off;
      if ($urandom_range(0, 1)) tx += off;
      else ty += off;
    end else begin
      reach = stride * $urandom_range(0, 70) + $urandom_range(0, 32'(stride));
      tx += longint'($urandom_range(0, 32'(2 * reach))) - reach;
      ty += longint'($urandom_range(0, 32'(2 * reach))) - reach;
    end
    offer_point(o, int'(clamp24(tx)), int'(clamp24(ty)));
    foreach (fresh[i]) dabs_due.push_back(fresh[i]);
    rest_input();
  endtask

  always @(posedge clk) begin
    if (out_hold != 0) begin
      out_ready <= 1'b0;
      out_hold <= out_hold - 1;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 399) == 0) smooth <= ~smooth;
      if (!smooth && $urandom_range(0, 3) == 0) out_hold <= idle_span();
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (dabs_due.size() == 0) begin
        faults++;
        $display("%0t: dab with none expected: left %0d top %0d last %0b",
                 $time, dab_left, dab_top, last_dab);
      end else begin
        want = dabs_due.pop_front();
        if (dab_left !== want.left || dab_top !== want.top || last_dab !== want.last) begin
          faults++;
          $display("%0t: dab mismatch: expected left %0d top %0d last %0b, got %0d %0d %0b",
                   $time, want.left, want.top, want.last, dab_left, dab_top, last_dab);
        end
      end
    end
  end

  initial begin
    int   bs, sp;
    dab_t d;
    // Default brush: step 640, half size 1280.
    add_row(0, bdls_pkg::OP_LINE, 1280, 0, 2, -1280, -1280, -640, -1280);
    add_row(0, bdls_pkg::OP_LINE, 1280, 0, 0);
    add_row(0, bdls_pkg::OP_LINE, 1919, 0, 0);
    add_row(0, bdls_pkg::OP_MOVE, 0, 0, 0);
    add_row(0, bdls_pkg::OP_LINE, 0, -1280, 2, -1280, -1280, -1280, -1920);
    add_row(0, bdls_pkg::OP_MOVE, 0, 0, 0);
    add_row(0, bdls_pkg::OP_LINE, 640, 0, 1, -1280, -1280);
    // The leftover part of each segment carries into the next one.
    add_row(0, bdls_pkg::OP_LINE, 1600, 0, 1, -640, -1280);
    add_row(0, bdls_pkg::OP_LINE, 1920, 0, 1, 0, -1280);
    add_row(0, bdls_pkg::OP_LINE, 640, 0, 2, 640, -1280, 0, -1280);
    add_row(0, bdls_pkg::OP_LINE, 3000, 2000, -1);
    add_row(0, bdls_pkg::OP_MOVE, EDGE_LO, EDGE_LO, 0);
    add_row(0, bdls_pkg::OP_LINE, EDGE_LO + 1280, EDGE_LO, 2, EDGE_LO, EDGE_LO, EDGE_LO,
            EDGE_LO);
    add_row(0, bdls_pkg::OP_MOVE, EDGE_HI, EDGE_HI, 0);
    add_row(0, bdls_pkg::OP_LINE, EDGE_HI, EDGE_HI - 1280, -1);
    add_row(0, bdls_pkg::OP_LINE, EDGE_LO, EDGE_LO, -1);
    add_row(0, bdls_pkg::OP_MOVE, EDGE_LO, EDGE_HI, 0);
    add_row(0, bdls_pkg::OP_LINE, EDGE_HI, EDGE_LO, -1);
    add_row(0, bdls_pkg::OP_MOVE, -1, -1, 0);
    add_row(0, bdls_pkg::OP_LINE, 40959, -1, -1);
    add_row(0, bdls_pkg::OP_LINE, 40959 + 41600, -1, -1);
    // Smallest brush: the step product floors to zero and is raised to one.
    add_row(1, bdls_pkg::OP_MOVE, 1, 1, 0);
    add_row(0, bdls_pkg::OP_MOVE, 0, 0, 0);
    add_row(0, bdls_pkg::OP_LINE, 3, 4, -1);
    add_row(0, bdls_pkg::OP_LINE, 3, 5, 1, 3, 4);
    add_row(1, bdls_pkg::OP_MOVE, 1048575, 4095, 0);
    add_row(0, bdls_pkg::OP_MOVE, EDGE_LO, EDGE_LO, 0);
    add_row(0, bdls_pkg::OP_LINE, EDGE_HI, EDGE_HI, -1);

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].setup) begin
        program_brush(plan[i].x, plan[i].y);
      end else begin
        offer_point(plan[i].op, plan[i].x, plan[i].y);
        if (plan[i].pins < 0) begin
          foreach (fresh[k]) dabs_due.push_back(fresh[k]);
        end else begin
          for (int k = 0; k < plan[i].pins; k++) begin
            d.left = 24'((k == 0) ? plan[i].l0 : plan[i].l1);
            d.top = 24'((k == 0) ? plan[i].t0 : plan[i].t1);
            d.last = (k == plan[i].pins - 1);
            dabs_due.push_back(d);
          end
        end
        rest_input();
      end
    end

    for (int p = 0; p < 8; p++) begin
      sp = $urandom_range(1, 4095);
      case (p)
        0: begin
          bs = int'(bdls_pkg::BRUSH_SIZE_RESET);
          sp = int'(bdls_pkg::SPACING_RESET);
        end
        1: begin
          bs = 1;
          sp = 1;
        end
        2: begin
          bs = 1048575;
          sp = 4095;
        end
        3: begin
          bs = 1;
          sp = 4095;
        end
        4: begin
          bs = 1048575;
          sp = 1;
        end
        5: bs = $urandom_range(1, 4096);
        default: bs = $urandom_range(1, 1048575);
      endcase
      program_brush(bs, sp);
      repeat (58) random_item();
    end

    in_valid <= 1'b0;
    while (dabs_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (faults == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ----- brush_dab_line_stepper_core.f -----
rtl/core/bdls_pkg.sv
rtl/core/bdls_rootdiv.sv
rtl/core/brush_dab_line_stepper_core.sv
tb/brush_dab_line_stepper_core_test.sv
